// ===== design/wlba_pkg.sv =====
// ----------------------------------------------------------------------------
// wlba_pkg
// Shared types and constants for the windowed latency breakdown averager.
// ----------------------------------------------------------------------------
package wlba_pkg;

    localparam int TIME_BITS         = 48;
    localparam int AVG_BITS          = 32;
    localparam int COUNT_BITS        = 7;
    localparam int NUM_STAGES        = 6;
    localparam int DEF_WINDOW_DEPTH  = 120;
    localparam int DEF_DURATION_BITS = 32;

    typedef struct packed {
        logic                 clear_window;
        logic [TIME_BITS-1:0] capture_time;
        logic [TIME_BITS-1:0] encode_time;
        logic [TIME_BITS-1:0] net_send_time;
        logic [TIME_BITS-1:0] net_recv_time;
        logic [TIME_BITS-1:0] jitter_ready_time;
        logic [TIME_BITS-1:0] decode_time;
        logic [TIME_BITS-1:0] present_time;
    } in_item_t;

    typedef struct packed {
        logic [COUNT_BITS-1:0] valid_count;
        logic [AVG_BITS-1:0]   avg_capture_to_encode;
        logic [AVG_BITS-1:0]   avg_network_transit;
        logic [AVG_BITS-1:0]   avg_jitter_delay;
        logic [AVG_BITS-1:0]   avg_decode_time;
        logic [AVG_BITS-1:0]   avg_present_delay;
        logic [AVG_BITS-1:0]   avg_end_to_end;
    } out_item_t;

    typedef enum logic [2:0] {
        STG_ENC,
        STG_NET,
        STG_JIT,
        STG_DEC,
        STG_PRES,
        STG_TOTAL
    } stage_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_SPAN,
        ST_UPDATE,
        ST_COMMIT,
        ST_DIVIDE,
        ST_DIV_WAIT,
        ST_DONE
    } state_t;

endpackage

// ===== design/windowed_latency_breakdown_averager_top.sv =====
// ----------------------------------------------------------------------------
// windowed_latency_breakdown_averager_top
// Sliding-window averages of per-stage frame latencies.
// ----------------------------------------------------------------------------
// usage
//   item channel: one request carries a clear flag or seven timestamps of a
//   frame; it is taken when item_valid is high and item_stall is low.
//   result channel: every request yields one result with the valid record
//   count and six truncated mean durations in microseconds.
//   a frame request runs through a slot read, six span steps, six sum
//   updates, a slot write and then six divisions on one shared serial
//   divider, or zero means when no valid record is held; a clear goes
//   straight to the division steps. item_stall stays high until the cycle
//   after the result is loaded, so no request is taken while one is in
//   progress.
//   the result sits in an output register; a new request is taken while it
//   waits, and if result_stall holds it, the next result waits in the
//   done state until the register frees.
//   reset clears sums, fill level, write slot and count; the slot memory
//   needs no clearing since an old record only counts once the window is full.
// ----------------------------------------------------------------------------
module windowed_latency_breakdown_averager_top
    import wlba_pkg::*;
#(
    parameter int WINDOW_DEPTH  = DEF_WINDOW_DEPTH,
    parameter int DURATION_BITS = DEF_DURATION_BITS
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      item_valid,
    output logic      item_stall,
    input  in_item_t  item,
    output logic      result_valid,
    input  logic      result_stall,
    output out_item_t result
);

    localparam int CNT_W  = $clog2(WINDOW_DEPTH + 1);
    localparam int SLOT_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int SUM_W  = DURATION_BITS + CNT_W;
    localparam int WORD_W = NUM_STAGES * DURATION_BITS + 1;
    localparam logic [TIME_BITS-1:0] DUR_MAX =
        {TIME_BITS{1'b1}} >> (TIME_BITS - DURATION_BITS);

    state_t state_reg, state_next;
    stage_t stage_reg;

    in_item_t            in_reg;
    logic                ok_reg;
    logic [CNT_W-1:0]    fill_reg;
    logic [CNT_W-1:0]    count_reg;
    logic [SLOT_W-1:0]   slot_reg;
    logic [SUM_W-1:0]    sum_reg [NUM_STAGES];
    logic [DURATION_BITS-1:0] dur_reg [NUM_STAGES];
    logic [AVG_BITS-1:0] avg_reg [NUM_STAGES];
    logic [WORD_W-1:0]   old_word_reg;
    logic [WORD_W-1:0]   mem [WINDOW_DEPTH];

    logic                result_valid_reg;
    out_item_t           result_reg;

    logic                accept;
    logic                last_stage;
    logic                full;
    logic                evict;
    logic                div_start;
    logic                div_done;
    logic [SUM_W-1:0]    div_quo;
    logic                out_free;

    logic [TIME_BITS-1:0] span_from;
    logic [TIME_BITS-1:0] span_to;
    logic [TIME_BITS-1:0] span_diff;
    logic [TIME_BITS-1:0] span_val;
    logic [SUM_W-1:0]     sum_new;
    logic [WORD_W-1:0]    new_word;
    logic [SUM_W+AVG_BITS-1:0]   quo_ext;
    logic [CNT_W+COUNT_BITS-1:0] cnt_ext;

    assign accept     = item_valid && !item_stall;
    assign last_stage = (stage_reg == STG_TOTAL);
    assign full       = (fill_reg == CNT_W'(WINDOW_DEPTH));
    assign evict      = full && old_word_reg[WORD_W-1];
    assign out_free   = !result_valid_reg || !result_stall;

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        item_stall = 1'b1;
        div_start  = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                item_stall = 1'b0;
                if (item_valid)
                    state_next = item.clear_window ? ST_DIVIDE : ST_READ;
            end
            ST_READ:
                state_next = ST_SPAN;
            ST_SPAN:
                if (last_stage)
                    state_next = ST_UPDATE;
            ST_UPDATE:
                if (last_stage)
                    state_next = ST_COMMIT;
            ST_COMMIT:
                state_next = ST_DIVIDE;
            ST_DIVIDE:
            begin
                if (count_reg != '0)
                begin
                    div_start  = 1'b1;
                    state_next = ST_DIV_WAIT;
                end
                else if (last_stage)
                    state_next = ST_DONE;
            end
            ST_DIV_WAIT:
                if (div_done)
                    state_next = last_stage ? ST_DONE : ST_DIVIDE;
            ST_DONE:
                if (out_free)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // endpoints of the span for the current stage
    always_comb
    begin
        unique case (stage_reg)
            STG_ENC:
            begin
                span_from = in_reg.capture_time;
                span_to   = in_reg.encode_time;
            end
            STG_NET:
            begin
                span_from = in_reg.net_send_time;
                span_to   = in_reg.net_recv_time;
            end
            STG_JIT:
            begin
                span_from = in_reg.net_recv_time;
                span_to   = in_reg.jitter_ready_time;
            end
            STG_DEC:
            begin
                span_from = in_reg.jitter_ready_time;
                span_to   = in_reg.decode_time;
            end
            STG_PRES:
            begin
                span_from = in_reg.decode_time;
                span_to   = in_reg.present_time;
            end
            STG_TOTAL:
            begin
                span_from = in_reg.capture_time;
                span_to   = in_reg.present_time;
            end
            default:
            begin
                span_from = '0;
                span_to   = '0;
            end
        endcase
    end

    assign span_diff = span_to - span_from;

    always_comb
    begin
        priority if (span_to < span_from)
            span_val = '0;
        else if (span_diff > DUR_MAX)
            span_val = DUR_MAX;
        else
            span_val = span_diff;
    end

    // drop the evicted record and add the new one in one pass
    always_comb
    begin
        sum_new = sum_reg[stage_reg];
        if (evict)
            sum_new = sum_new
                - SUM_W'(old_word_reg[stage_reg*DURATION_BITS +: DURATION_BITS]);
        if (ok_reg)
            sum_new = sum_new + SUM_W'(dur_reg[stage_reg]);
    end

    always_comb
    begin
        new_word = '0;
        for (int k = 0; k < NUM_STAGES; k++)
            new_word[k*DURATION_BITS +: DURATION_BITS] = dur_reg[k];
        new_word[WORD_W-1] = ok_reg;
    end

    assign quo_ext = {{AVG_BITS{1'b0}}, div_quo};
    assign cnt_ext = {{COUNT_BITS{1'b0}}, count_reg};

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_reg        <= STG_ENC;
            fill_reg         <= '0;
            count_reg        <= '0;
            slot_reg         <= '0;
            result_valid_reg <= 1'b0;
            for (int k = 0; k < NUM_STAGES; k++)
                sum_reg[k] <= '0;
        end
        else
        begin
            if (state_reg == ST_DONE && out_free)
                result_valid_reg <= 1'b1;
            else if (result_valid_reg && !result_stall)
                result_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_IDLE:
                begin
                    stage_reg <= STG_ENC;
                    if (accept && item.clear_window)
                    begin
                        fill_reg  <= '0;
                        count_reg <= '0;
                        slot_reg  <= '0;
                        for (int k = 0; k < NUM_STAGES; k++)
                            sum_reg[k] <= '0;
                    end
                end
                ST_READ:
                    stage_reg <= STG_ENC;
                ST_SPAN, ST_UPDATE:
                begin
                    stage_reg <= last_stage ? STG_ENC : stage_t'(stage_reg + 1'b1);
                    if (state_reg == ST_UPDATE)
                        sum_reg[stage_reg] <= sum_new;
                end
                ST_COMMIT:
                begin
                    stage_reg <= STG_ENC;
                    count_reg <= count_reg - CNT_W'(evict) + CNT_W'(ok_reg);
                    if (!full)
                        fill_reg <= fill_reg + 1'b1;
                    if (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
                        slot_reg <= '0;
                    else
                        slot_reg <= slot_reg + 1'b1;
                end
                ST_DIVIDE:
                    if (count_reg == '0 && !last_stage)
                        stage_reg <= stage_t'(stage_reg + 1'b1);
                ST_DIV_WAIT:
                    if (div_done && !last_stage)
                        stage_reg <= stage_t'(stage_reg + 1'b1);
                ST_DONE:
                    stage_reg <= STG_ENC;
                default:
                    stage_reg <= STG_ENC;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            in_reg <= item;
            ok_reg <= (item.present_time > item.capture_time) && (item.capture_time != '0);
        end
        if (state_reg == ST_SPAN)
            dur_reg[stage_reg] <= DURATION_BITS'(span_val);
        if (state_reg == ST_DIVIDE && count_reg == '0)
            avg_reg[stage_reg] <= '0;
        if (state_reg == ST_DIV_WAIT && div_done)
            avg_reg[stage_reg] <= quo_ext[AVG_BITS-1:0];
        if (state_reg == ST_DONE && out_free)
        begin
            result_reg.valid_count           <= cnt_ext[COUNT_BITS-1:0];
            result_reg.avg_capture_to_encode <= avg_reg[STG_ENC];
            result_reg.avg_network_transit   <= avg_reg[STG_NET];
            result_reg.avg_jitter_delay      <= avg_reg[STG_JIT];
            result_reg.avg_decode_time       <= avg_reg[STG_DEC];
            result_reg.avg_present_delay     <= avg_reg[STG_PRES];
            result_reg.avg_end_to_end        <= avg_reg[STG_TOTAL];
        end
    end

    // slot memory: one record per slot, valid mark on top
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_READ)
            old_word_reg <= mem[slot_reg];
        if (state_reg == ST_COMMIT)
            mem[slot_reg] <= new_word;
    end

    wlba_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (CNT_W)
    ) u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_reg[stage_reg]),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// ===== design/wlba_divider.sv =====
// ----------------------------------------------------------------------------
// wlba_divider
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module wlba_divider
    import wlba_pkg::*;
#(
    parameter int DIVIDEND_W = DEF_DURATION_BITS + COUNT_BITS,
    parameter int DIVISOR_W  = COUNT_BITS
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    localparam int ITER_W = (DIVIDEND_W > 1) ? $clog2(DIVIDEND_W) : 1;

    logic                  busy_reg;
    logic                  done_reg;
    logic [ITER_W-1:0]     iter_reg;
    logic [DIVISOR_W-1:0]  rem_reg;
    logic [DIVISOR_W-1:0]  dsr_reg;
    logic [DIVIDEND_W-1:0] quo_reg;

    logic [DIVISOR_W:0]    trial;
    logic [DIVISOR_W:0]    diff;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign diff  = trial - {1'b0, dsr_reg};
    assign fits  = (trial >= {1'b0, dsr_reg});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            iter_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                iter_reg <= ITER_W'(DIVIDEND_W - 1);
            end
            else if (busy_reg)
            begin
                iter_reg <= iter_reg - 1'b1;
                if (iter_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dsr_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            rem_reg <= fits ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== design/wlba_checker.sv =====
// ----------------------------------------------------------------------------
// wlba_checker
// Port-level checks for the latency breakdown averager, bound to the top.
// ----------------------------------------------------------------------------
module wlba_checker
    import wlba_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      item_valid,
    input logic      item_stall,
    input in_item_t  item,
    input logic      result_valid,
    input logic      result_stall,
    input out_item_t result
);

    // a held result must not move
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // an empty window reports zero means
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.valid_count == '0 |->
            result.avg_capture_to_encode == '0 && result.avg_network_transit == '0 &&
            result.avg_jitter_delay == '0 && result.avg_decode_time == '0 &&
            result.avg_present_delay == '0 && result.avg_end_to_end == '0)
        else $error("nonzero mean with empty window");

    // the block is busy right after taking a request
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall |=> item_stall)
        else $error("request taken while previous one in progress");

    // a clear request never sees its result in the next cycle
    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && !item_stall && item.clear_window && !result_valid |=>
            !result_valid)
        else $error("result appeared too early");

endmodule

bind windowed_latency_breakdown_averager_top wlba_checker u_checker (.*);

// ===== test/tb_windowed_latency_breakdown_averager_top.sv =====
// ----------------------------------------------------------------------------
// tb_windowed_latency_breakdown_averager_top
// Drives frame timestamp requests and window clears into the latency
// averager and checks every result against an in-bench model of the
// 120-slot sliding window, its running stage sums and the truncated means.
// A short table of directed requests comes first, then random frames, with
// random idling on both channels and two long result holds.
// ----------------------------------------------------------------------------
module tb_windowed_latency_breakdown_averager_top;
    import wlba_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int WINDOW        = DEF_WINDOW_DEPTH;
    localparam int DUR_BITS      = DEF_DURATION_BITS;
    localparam int SUM_BITS      = DUR_BITS + COUNT_BITS;
    localparam int FRAME_COUNT   = 1900;
    localparam int PRESSURE_HOLD = 3000;
    localparam int DRAIN_CYCLES  = 600;

    localparam bit [TIME_BITS-1:0] T_TOP    = '1;
    localparam bit [TIME_BITS-1:0] DUR_CEIL = (48'd1 << DUR_BITS) - 1;
    localparam out_item_t          NO_RECORDS = '0;
    localparam out_item_t          ONE_FRAME  =
        '{7'd1, 32'd500, 32'd1000, 32'd100, 32'd300, 32'd500, 32'd2500};

    typedef struct {
        in_item_t  stim;
        bit        known;
        out_item_t want;
    } vector_row_t;

    logic      clk;
    logic      rst_n;
    logic      item_valid;
    logic      item_stall;
    in_item_t  item;
    logic      result_valid;
    logic      result_stall;
    out_item_t result;

    // window model
    bit [DUR_BITS-1:0] slot_span [WINDOW][NUM_STAGES];
    bit                slot_ok [WINDOW];
    bit [SUM_BITS-1:0] stage_total [NUM_STAGES];
    int unsigned       held;
    int unsigned       next_slot;
    int unsigned       valid_held;

    out_item_t   expected_q[$];
    vector_row_t directed_rows[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned sent;

    windowed_latency_breakdown_averager_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    function automatic void add_row(vector_row_t row);
        directed_rows.insert(directed_rows.size(), row);
    endfunction

    function automatic bit [DUR_BITS-1:0] clamp_span(bit [TIME_BITS-1:0] from_t,
                                                     bit [TIME_BITS-1:0] to_t);
        bit [TIME_BITS-1:0] diff;
        if (to_t < from_t)
            return '0;
        diff = to_t - from_t;
        if (diff > DUR_CEIL)
            return '1;
        return diff[DUR_BITS-1:0];
    endfunction

    function automatic out_item_t apply_frame(in_item_t x);
        bit [DUR_BITS-1:0] d [NUM_STAGES];
        bit                frame_ok;
        int unsigned       slot;
        out_item_t         r;
        r = '0;
        if (x.clear_window)
        begin
            for (int k = 0; k < NUM_STAGES; k++)
                stage_total[k] = '0;
            held       = 0;
            next_slot  = 0;
            valid_held = 0;
        end
        else
        begin
            frame_ok = (x.present_time > x.capture_time) && (x.capture_time != '0);
            slot     = next_slot;
            // full window: the slot being overwritten leaves the sums
            if (held >= WINDOW)
            begin
                if (slot_ok[slot])
                begin
                    for (int k = 0; k < NUM_STAGES; k++)
                        stage_total[k] -= slot_span[slot][k];
                    valid_held--;
                end
            end
            else
                held++;
            d[STG_ENC]   = clamp_span(x.capture_time, x.encode_time);
            d[STG_NET]   = clamp_span(x.net_send_time, x.net_recv_time);
            d[STG_JIT]   = clamp_span(x.net_recv_time, x.jitter_ready_time);
            d[STG_DEC]   = clamp_span(x.jitter_ready_time, x.decode_time);
            d[STG_PRES]  = clamp_span(x.decode_time, x.present_time);
            d[STG_TOTAL] = clamp_span(x.capture_time, x.present_time);
            for (int k = 0; k < NUM_STAGES; k++)
                slot_span[slot][k] = d[k];
            slot_ok[slot] = frame_ok;
            if (frame_ok)
            begin
                for (int k = 0; k < NUM_STAGES; k++)
                    stage_total[k] += d[k];
                valid_held++;
            end
            next_slot = (slot + 1) % WINDOW;
        end
        r.valid_count = COUNT_BITS'(valid_held);
        if (valid_held != 0)
        begin
            r.avg_capture_to_encode = AVG_BITS'(stage_total[STG_ENC] / valid_held);
            r.avg_network_transit   = AVG_BITS'(stage_total[STG_NET] / valid_held);
            r.avg_jitter_delay      = AVG_BITS'(stage_total[STG_JIT] / valid_held);
            r.avg_decode_time       = AVG_BITS'(stage_total[STG_DEC] / valid_held);
            r.avg_present_delay     = AVG_BITS'(stage_total[STG_PRES] / valid_held);
            r.avg_end_to_end        = AVG_BITS'(stage_total[STG_TOTAL] / valid_held);
        end
        return r;
    endfunction

    function automatic bit [TIME_BITS-1:0] rand_stamp();
        return {16'($urandom), 32'($urandom)};
    endfunction

    // mostly forward steps, now and then a stage that runs backwards
    function automatic bit [TIME_BITS-1:0] next_stamp(bit [TIME_BITS-1:0] prev);
        bit [TIME_BITS-1:0] step;
        step = TIME_BITS'($urandom_range(0, 1 << 20));
        return ($urandom_range(0, 7) == 0) ? prev - step : prev + step;
    endfunction

    function automatic in_item_t random_frame();
        in_item_t    x;
        int unsigned pick;
        pick           = $urandom_range(0, 99);
        x              = '0;
        x.clear_window = ($urandom_range(0, 249) == 0);
        if (pick < 70)
        begin
            x.capture_time      = {16'($urandom_range(1, 16'hFFFE)), 32'($urandom)};
            x.encode_time       = next_stamp(x.capture_time);
            x.net_send_time     = next_stamp(x.encode_time);
            x.net_recv_time     = next_stamp(x.net_send_time);
            x.jitter_ready_time = next_stamp(x.net_recv_time);
            x.decode_time       = next_stamp(x.jitter_ready_time);
            x.present_time      = next_stamp(x.decode_time);
        end
        else if (pick < 80)
        begin
            // early capture against far-off stamps: long, saturating spans
            x.capture_time      = TIME_BITS'($urandom_range(1, 1000));
            x.encode_time       = rand_stamp();
            x.net_send_time     = rand_stamp();
            x.net_recv_time     = rand_stamp();
            x.jitter_ready_time = rand_stamp();
            x.decode_time       = rand_stamp();
            x.present_time      = rand_stamp();
        end
        else
        begin
            x.capture_time      = rand_stamp();
            x.encode_time       = rand_stamp();
            x.net_send_time     = rand_stamp();
            x.net_recv_time     = rand_stamp();
            x.jitter_ready_time = rand_stamp();
            x.decode_time       = rand_stamp();
            x.present_time      = rand_stamp();
            if (pick < 90)
            begin
                case ($urandom_range(0, 2))
                    0: x.capture_time = '0;
                    1: x.present_time = x.capture_time;
                    default: x.present_time =
                        x.capture_time - TIME_BITS'($urandom_range(1, 5000));
                endcase
            end
        end
        return x;
    endfunction

    task automatic offer_request(in_item_t x, bit known, out_item_t want);
        int unsigned gap;
        out_item_t   predicted;
        gap = ((sent % 300) < 50) ? 0 : $urandom_range(0, 9);
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item       <= x;
        item_valid <= 1'b1;
        do
            @(posedge clk);
        while (item_stall);
        predicted = apply_frame(x);
        expected_q.insert(expected_q.size(), known ? want : predicted);
        sent++;
    endtask

    task automatic check_result(out_item_t got);
        out_item_t want;
        results_seen++;
        if (expected_q.size() == 0)
        begin
            if (mismatches < 10)
                $display("result %0d arrived with nothing outstanding", results_seen);
            mismatches++;
            return;
        end
        want = expected_q[0];
        expected_q.delete(0);
        if (got.valid_count           !== want.valid_count           ||
            got.avg_capture_to_encode !== want.avg_capture_to_encode ||
            got.avg_network_transit   !== want.avg_network_transit   ||
            got.avg_jitter_delay      !== want.avg_jitter_delay      ||
            got.avg_decode_time       !== want.avg_decode_time       ||
            got.avg_present_delay     !== want.avg_present_delay     ||
            got.avg_end_to_end        !== want.avg_end_to_end)
        begin
            if (mismatches < 10)
                $display("result %0d mismatch: want %0d %0d %0d %0d %0d %0d %0d",
                         results_seen,
                         want.valid_count, want.avg_capture_to_encode,
                         want.avg_network_transit, want.avg_jitter_delay,
                         want.avg_decode_time, want.avg_present_delay,
                         want.avg_end_to_end,
                         " got %0d %0d %0d %0d %0d %0d %0d",
                         got.valid_count, got.avg_capture_to_encode,
                         got.avg_network_transit, got.avg_jitter_delay,
                         got.avg_decode_time, got.avg_present_delay,
                         got.avg_end_to_end);
            mismatches++;
        end
    endtask

    // result side: random holds counted only while a result waits
    initial
    begin
        int unsigned stall_left;
        stall_left   = 0;
        result_stall = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (result_valid && !result_stall)
            begin
                check_result(result);
                if (results_seen == 300 || results_seen == 1200)
                    stall_left = PRESSURE_HOLD;
                else if ((results_seen % 250) < 50)
                    stall_left = 0;
                else
                    stall_left = $urandom_range(0, 9);
            end
            else if (result_valid && stall_left > 0)
                stall_left--;
            result_stall <= (stall_left > 0);
        end
    end

    initial
    begin
        int n;
        item_valid = 1'b0;
        item       = '0;
        rst_n      = 1'b0;
        held       = 0;
        next_slot  = 0;
        valid_held = 0;
        for (int k = 0; k < NUM_STAGES; k++)
            stage_total[k] = '0;

        add_row('{'{1'b1, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
                  1'b1, NO_RECORDS});
        // unknown capture
        add_row('{'{1'b0, 48'd0, 48'd10, 48'd20, 48'd30, 48'd40, 48'd50,
                    48'd60}, 1'b1, NO_RECORDS});
        // present equal to capture
        add_row('{'{1'b0, 48'd500, 48'd600, 48'd700, 48'd800, 48'd900,
                    48'd1000, 48'd500}, 1'b1, NO_RECORDS});
        // present before capture
        add_row('{'{1'b0, 48'd900, 48'd950, 48'd960, 48'd970, 48'd980,
                    48'd990, 48'd100}, 1'b1, NO_RECORDS});
        add_row('{'{1'b0, 48'd1000, 48'd1500, 48'd1600, 48'd2600, 48'd2700,
                    48'd3000, 48'd3500}, 1'b1, ONE_FRAME});
        // every stage from capture to decode runs backwards
        add_row('{'{1'b0, 48'd100, 48'd50, 48'd500, 48'd400, 48'd300,
                    48'd200, 48'd1000}, 1'b0, NO_RECORDS});
        // capture at one, everything else at the top
        add_row('{'{1'b0, 48'd1, T_TOP, T_TOP, T_TOP, T_TOP, T_TOP, T_TOP},
                  1'b0, NO_RECORDS});
        add_row('{'{1'b0, T_TOP, T_TOP, T_TOP, T_TOP, T_TOP, T_TOP, T_TOP},
                  1'b0, NO_RECORDS});
        add_row('{'{1'b0, T_TOP - 1, T_TOP, T_TOP, T_TOP, T_TOP, T_TOP,
                    T_TOP}, 1'b0, NO_RECORDS});
        // spans right at and one past the duration ceiling
        add_row('{'{1'b0, 48'd1, 48'h1_0000_0001, 48'd0, 48'hFFFF_FFFF,
                    48'd0, 48'd0, 48'h1_0000_0000}, 1'b0, NO_RECORDS});
        add_row('{'{1'b1, T_TOP, T_TOP, T_TOP, T_TOP, T_TOP, T_TOP, T_TOP},
                  1'b1, NO_RECORDS});
        add_row('{'{1'b0, 48'd1000, 48'd1500, 48'd1600, 48'd2600, 48'd2700,
                    48'd3000, 48'd3500}, 1'b1, ONE_FRAME});
        // invalid record takes a slot and leaves the means alone
        add_row('{'{1'b0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0, 48'd0},
                  1'b1, ONE_FRAME});
        add_row('{'{1'b1, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                    48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                    48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                    48'h5555_5555_5555}, 1'b1, NO_RECORDS});
        add_row('{'{1'b0, 48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                    48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                    48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA,
                    48'hAAAA_AAAA_AAAA}, 1'b0, NO_RECORDS});

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_rows[i])
            offer_request(directed_rows[i].stim, directed_rows[i].known,
                          directed_rows[i].want);
        for (n = directed_rows.size(); n < FRAME_COUNT; n++)
            offer_request(random_frame(), 1'b0, NO_RECORDS);
        item_valid <= 1'b0;

        while (expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatches == 0 && expected_q.size() == 0)
            $display("tb_windowed_latency_breakdown_averager_top OK");
        else
            $display("tb_windowed_latency_breakdown_averager_top NOT OK");
        $finish;
    end

    // slowest correct run, two long holds included, is roughly 2.3 ms
    // at 4 ns; allow several times that
    initial
    begin
        #20_000_000;
        $display("tb_windowed_latency_breakdown_averager_top NOT OK");
        $finish;
    end

endmodule

// ===== filelist.f =====
design/wlba_pkg.sv
design/wlba_divider.sv
design/windowed_latency_breakdown_averager_top.sv
design/wlba_checker.sv
test/tb_windowed_latency_breakdown_averager_top.sv
